// File: design/otq_pkg.sv
// ---------------------------------------------------------------------------
// otq_pkg - shared types and constants of the ordered timer queue
//
// Field widths, opcode and status codes, the slot memory word and the
// default configuration values.
// ---------------------------------------------------------------------------
`default_nettype none

package otq_pkg;

  // Field widths
  localparam int TIME_W  = 62;
  localparam int IVL_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int DELAY_W = 20;

  // Defaults
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST = DELAY_W'(100);

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_RSVD   = 2'd3
  } otq_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_ARMED    = 2'd1,
    STS_UNARMED  = 2'd2,
    STS_BAD_OP   = 2'd3
  } otq_status_t;

  // One slot memory word
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [IVL_W-1:0]  interval;
  } otq_word_t;

endpackage

`default_nettype wire

// File: design/otq_slot_mem.sv
// ---------------------------------------------------------------------------
// otq_slot_mem - slot expiry and interval store
//
// One write port and one read port, read data registered.
// Contents are undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module otq_slot_mem
  import otq_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire otq_word_t     wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output otq_word_t          rd_data
);

  otq_word_t mem [TIMER_SLOTS];
  otq_word_t rd_data_r;

  // Write, then read registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/ordered_timer_queue.sv
// ---------------------------------------------------------------------------
// ordered_timer_queue - timer slots fired in order of expiry
//
// Add, cancel and tick items work on a slot table held in a synchronous
// memory; every result carries the earliest pending expiry and arm delay.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall   opcode, slot, expiry, interval, now
//   out_     out        out_valid/out_stall fired, slot, last, earliest, delay
//   cfg_     in         cfg_wr_en           min_arm_delay (20 bits)
//
// A scan pass walks the slot memory one slot a cycle. Add, cancel and bad opcode run
// one earliest pass, then the ST_NEXT and ST_DLY steps and one emit. A tick with n
// firings runs n + 1 selection passes (n when MAX_RESULTS fire), an update after each
// firing, one earliest pass, the ST_NEXT and ST_DLY steps and max(n, 1) emits. Armed
// bits clear at reset; the slot memory needs no clearing. A new item is taken once the
// last result sits in the output register; a stalled output holds it and the next item waits.
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_timer_queue
  import otq_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [DELAY_W-1:0]  cfg_wr_data,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [SLOT_W-1:0]   in_timer_slot,
  input  wire logic [TIME_W-1:0]   in_expiry_time,
  input  wire logic [IVL_W-1:0]    in_repeat_interval,
  input  wire logic [TIME_W-1:0]   in_now_time,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_fired,
  output logic [SLOT_W-1:0]        out_fired_slot,
  output logic                     out_last,
  output logic                     out_earliest_changed,
  output logic                     out_next_valid,
  output logic [TIME_W-1:0]        out_next_expiry,
  output logic [TIME_W-1:0]        out_arm_delay,
  output logic [1:0]               out_status
);

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int KW = $clog2(MAX_RESULTS);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_NEXT,
    ST_DLY,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic [DELAY_W-1:0]   min_delay_r;

  // Slot state
  logic [TIMER_SLOTS-1:0] armed_r;
  logic [TIMER_SLOTS-1:0] taken_r;

  // Latched item
  otq_op_t              op_r;
  otq_status_t          status_r;
  logic [TIME_W-1:0]    exp_in_r;
  logic [TIME_W-1:0]    now_r;
  logic                 excl_en_r;
  logic [SW-1:0]        excl_idx_r;

  // Scan
  logic                 sel_mode_r;
  logic [CW-1:0]        cnt_r;
  logic [SW-1:0]        rd_idx_r;
  logic                 rd_armed_r;
  logic                 found_r;
  logic [SW-1:0]        best_idx_r;
  logic [TIME_W-1:0]    best_exp_r;
  logic [IVL_W-1:0]     best_ivl_r;

  // Firing order and results
  logic [SW-1:0]        order_r [MAX_RESULTS];
  logic [NW-1:0]        n_r;
  logic [KW-1:0]        k_r;
  logic                 nvld_r;
  logic                 chg_r;
  logic [TIME_W-1:0]    next_r;
  logic [TIME_W-1:0]    delay_r;

  // Output register
  logic                 out_valid_r;
  logic                 out_fired_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_last_r;
  logic                 out_chg_r;
  logic                 out_nvld_r;
  logic [TIME_W-1:0]    out_next_r;
  logic [TIME_W-1:0]    out_delay_r;
  otq_status_t          out_status_r;

  // Memory ports
  logic                 mem_we;
  logic [SW-1:0]        mem_waddr;
  otq_word_t            mem_wdata;
  logic [SW-1:0]        scan_addr;
  otq_word_t            rd_word;

  // Helpers
  logic                 in_acc;
  logic                 slot_ok;
  logic [SW-1:0]        slot_idx;
  logic                 scan_done;
  logic                 cand;
  logic                 found_nxt;
  logic [TIME_W:0]      rearm_sum;
  logic [TIME_W-1:0]    rearm_exp;
  logic [TIME_W-1:0]    dly_diff;
  logic [TIME_W-1:0]    dly_raw;
  logic [TIME_W-1:0]    min_ext;
  logic                 out_free;
  logic [NW-1:0]        n_inc;
  logic                 emit_last;

  otq_slot_mem #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (scan_addr),
    .rd_data (rd_word)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = ({6'd0, in_timer_slot} < 10'(TIMER_SLOTS));
  assign slot_idx = SW'(in_timer_slot);

  // Scan address: slot under read, parked at zero after the last one
  assign scan_done = (cnt_r == CW'(TIMER_SLOTS));
  assign scan_addr = scan_done ? '0 : cnt_r[SW-1:0];

  // Candidate test on the slot whose data returns this cycle
  always_comb begin
    cand = (cnt_r != '0) && rd_armed_r && (!found_r || (rd_word.expiry < best_exp_r));
    if (sel_mode_r) begin
      cand = cand && !taken_r[rd_idx_r] && (rd_word.expiry <= now_r);
    end else begin
      cand = cand && !(excl_en_r && (rd_idx_r == excl_idx_r));
    end
  end
  assign found_nxt = found_r || cand;

  // Re-arm at expiry plus interval, saturating
  assign rearm_sum  = {1'b0, best_exp_r} + {{(TIME_W-IVL_W+1){1'b0}}, best_ivl_r};
  assign rearm_exp  = rearm_sum[TIME_W] ? '1 : rearm_sum[TIME_W-1:0];

  // Memory write: add on accept, re-arm on update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx_r;
    mem_wdata = '{expiry: rearm_exp, interval: best_ivl_r};
    if ((state_r == ST_IDLE) && in_acc && (otq_op_t'(in_opcode) == OP_ADD) && slot_ok &&
        !armed_r[slot_idx]) begin
      mem_we    = 1'b1;
      mem_waddr = slot_idx;
      mem_wdata = '{expiry: in_expiry_time, interval: in_repeat_interval};
    end else if ((state_r == ST_UPD) && (best_ivl_r != '0)) begin
      mem_we    = 1'b1;
    end
  end

  // Arm delay: difference to now, raised to the floor
  assign dly_diff = next_r - now_r;
  assign dly_raw  = (next_r > now_r) ? dly_diff : '0;
  assign min_ext  = TIME_W'(min_delay_r);

  assign out_free  = !out_valid_r || !out_stall;
  assign n_inc     = n_r + NW'(1);
  assign emit_last = (n_r == '0) || ((NW'(k_r) + NW'(1)) == n_r);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r <= MIN_DELAY_RST;
    end else if (cfg_wr_en) begin
      min_delay_r <= cfg_wr_data;
    end
  end

  // Scan read pipeline
  always_ff @(posedge clk) begin
    rd_idx_r   <= scan_addr;
    rd_armed_r <= armed_r[scan_addr];
  end

  // Sequencer, slot flags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r       <= otq_op_t'(in_opcode);
            exp_in_r   <= in_expiry_time;
            now_r      <= in_now_time;
            cnt_r      <= '0;
            found_r    <= 1'b0;
            excl_en_r  <= 1'b0;
            excl_idx_r <= slot_idx;
            sel_mode_r <= 1'b0;
            n_r        <= '0;
            status_r   <= STS_OK;
            state_r    <= ST_SCAN;
            unique case (otq_op_t'(in_opcode))
              OP_ADD: begin
                if (slot_ok && !armed_r[slot_idx]) begin
                  armed_r[slot_idx] <= 1'b1;
                  excl_en_r         <= 1'b1;
                end else begin
                  status_r <= STS_ARMED;
                end
              end
              OP_CANCEL: begin
                if (slot_ok && armed_r[slot_idx]) begin
                  armed_r[slot_idx] <= 1'b0;
                end else begin
                  status_r <= STS_UNARMED;
                end
              end
              OP_TICK: begin
                taken_r    <= '0;
                sel_mode_r <= 1'b1;
              end
              OP_RSVD: begin
                status_r <= STS_BAD_OP;
              end
              default: begin
                status_r <= STS_BAD_OP;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // advance one slot, keep the best candidate
          cnt_r   <= cnt_r + CW'(1);
          found_r <= found_nxt;
          if (cand) begin
            best_idx_r <= rd_idx_r;
            best_exp_r <= rd_word.expiry;
            best_ivl_r <= rd_word.interval;
          end
          if (scan_done) begin
            if (!sel_mode_r) begin
              state_r <= ST_NEXT;
            end else if (found_nxt) begin
              state_r <= ST_UPD;
            end else begin
              sel_mode_r <= 1'b0;
              cnt_r      <= '0;
              found_r    <= 1'b0;
            end
          end
        end

        ST_UPD: begin
          // record the firing, re-arm or disarm the slot
          taken_r[best_idx_r]     <= 1'b1;
          order_r[n_r[KW-1:0]]    <= best_idx_r;
          n_r                     <= n_inc;
          if (best_ivl_r == '0) begin
            armed_r[best_idx_r] <= 1'b0;
          end
          sel_mode_r <= (n_inc != NW'(MAX_RESULTS));
          cnt_r      <= '0;
          found_r    <= 1'b0;
          state_r    <= ST_SCAN;
        end

        ST_NEXT: begin
          // earliest pending expiry after the step
          if (excl_en_r) begin
            nvld_r <= 1'b1;
            if (!found_r || (exp_in_r < best_exp_r)) begin
              chg_r  <= 1'b1;
              next_r <= exp_in_r;
            end else begin
              chg_r  <= 1'b0;
              next_r <= best_exp_r;
            end
          end else begin
            nvld_r <= found_r;
            chg_r  <= 1'b0;
            next_r <= found_r ? best_exp_r : '0;
          end
          state_r <= ST_DLY;
        end

        ST_DLY: begin
          if (!nvld_r) begin
            delay_r <= '0;
          end else if (dly_raw < min_ext) begin
            delay_r <= min_ext;
          end else begin
            delay_r <= dly_raw;
          end
          k_r     <= '0;
          state_r <= ST_EMIT;
        end

        ST_EMIT: begin
          // load one result when the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_fired_r  <= (op_r == OP_TICK) && (n_r != '0);
            out_slot_r   <= ((op_r == OP_TICK) && (n_r != '0)) ?
                            SLOT_W'(order_r[k_r]) : '0;
            out_last_r   <= emit_last;
            out_chg_r    <= chg_r;
            out_nvld_r   <= nvld_r;
            out_next_r   <= next_r;
            out_delay_r  <= delay_r;
            out_status_r <= status_r;
            k_r          <= k_r + KW'(1);
            if (emit_last) begin
              state_r <= ST_IDLE;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_fired            = out_fired_r;
  assign out_fired_slot       = out_slot_r;
  assign out_last             = out_last_r;
  assign out_earliest_changed = out_chg_r;
  assign out_next_valid       = out_nvld_r;
  assign out_next_expiry      = out_next_r;
  assign out_arm_delay        = out_delay_r;
  assign out_status           = out_status_r;

endmodule

`default_nettype wire
